// File: hw/rtl/esp_pkg.sv
// Shared types and constants for the emulated x86 stack push/pop block.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package esp_pkg;

    localparam int STACK_BYTES = 4096;
    localparam int OFF_W       = $clog2(STACK_BYTES + 1);
    localparam int ROWS        = (STACK_BYTES + 3) / 4;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int DATA_W      = 32;

    // operation kind
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // operand width codes
    localparam logic [1:0] W_8   = 2'd0;
    localparam logic [1:0] W_16  = 2'd1;
    localparam logic [1:0] W_32  = 2'd2;
    localparam logic [1:0] W_BAD = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_BADWIDTH  = 2'd3;

    typedef struct packed {
        logic              kind;
        logic [1:0]        width;
        logic [DATA_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] pop_value;
        logic [DATA_W-1:0] stack_address;
        logic [1:0]        status;
    } t_out_item;

endpackage

// File: hw/rtl/esp_if.sv
// Valid/ready channel interfaces for the stack block.
// Depends on esp_pkg for the payload types.
`timescale 1ns / 1ps

interface esp_in_if;
    import esp_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface esp_out_if;
    import esp_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/emulated_x86_stack_push_pop.sv
// Top level: byte-addressed downward-growing stack with push/pop transactions.
// Depends on esp_pkg and the channel interfaces in esp_if.sv.
`timescale 1ns / 1ps

// Channel     Dir  Handshake      Payload
// i_in        in   valid/ready    kind, width, push_value
// o_out       out  valid/ready    pop_value, stack_address, status
// i_cfg_*     in   write enable   stack_start (32 bit)
//
// Sustains one transaction per cycle while o_out is not stalled. After the
// accepting edge a transaction passes the middle stage, with the registered
// read of the byte-lane memories, and then the output register, which drives
// o_out.valid.
// Reset (synchronous, active low) empties the stack and clears stack_start;
// memory contents stay undefined until written.
// A stalled o_out holds the result; the middle stage and the read data hold
// with it, so i_in.ready drops only when both stages are full.

module emulated_x86_stack_push_pop (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    esp_in_if.sink                       i_in,
    esp_out_if.source                    o_out,
    input  logic                         i_cfg_we,
    input  logic [esp_pkg::DATA_W-1:0]   i_cfg_wdata
);
    import esp_pkg::*;

    // Architectural state: stack offset (STACK_BYTES = empty) and base address.
    logic [OFF_W-1:0]  r_off;
    logic [DATA_W-1:0] r_start;

    // Middle stage: waits for memory read data.
    logic              r_s1_valid;
    logic              r_s1_pop;     // successful pop, read data is meaningful
    logic              r_s1_half;    // 16-bit pop: upper half is zero
    logic [1:0]        r_s1_lane0;   // bank holding byte 0 of the pop
    logic [DATA_W-1:0] r_s1_addr;
    logic [1:0]        r_s1_status;

    // Output register.
    logic              r_out_valid;
    t_out_item         r_out;

    // Registered read data, one byte per bank.
    logic [7:0]        r_rd [4];

    // Decode of the incoming transaction.
    logic              acc;
    logic              s1_adv;
    logic              is_pop;
    logic              is_half;
    logic [2:0]        nbytes;
    logic              bad_width;
    logic              overflow;
    logic              underflow;
    logic              op_ok;
    logic [1:0]        status;
    logic [OFF_W-1:0]  n_off;
    logic [OFF_W-1:0]  base;
    logic [DATA_W-1:0] push_word;

    // Per-bank access controls.
    logic [ROW_W-1:0]  bank_row [4];
    logic              bank_we  [4];
    logic              bank_re  [4];
    logic [7:0]        bank_wd  [4];

    logic [DATA_W-1:0] pop_word;

    // Handshake: the middle stage moves on whenever the output register is
    // free or being emptied; a new transaction enters behind it.
    assign s1_adv     = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign acc        = i_in.valid && i_in.ready;

    assign is_pop    = (i_in.data.kind == KIND_POP);
    assign is_half   = (i_in.data.width == W_16);
    assign nbytes    = is_half ? 3'd2 : 3'd4;
    // 8-bit pop counts as invalid width; this check wins over bound checks
    assign bad_width = (i_in.data.width == W_BAD) || (is_pop && i_in.data.width == W_8);
    assign overflow  = !is_pop && (r_off < OFF_W'(nbytes));
    assign underflow = is_pop &&
        (({1'b0, r_off} + (OFF_W + 1)'(nbytes)) > (OFF_W + 1)'(STACK_BYTES));
    assign op_ok     = !bad_width && !overflow && !underflow;

    always_comb begin
        if (bad_width) begin
            status = ST_BADWIDTH;
        end else if (overflow) begin
            status = ST_OVERFLOW;
        end else if (underflow) begin
            status = ST_UNDERFLOW;
        end else begin
            status = ST_OK;
        end
    end

    // Push lowers the offset first and writes there; pop reads at the
    // current offset and raises it afterwards.
    always_comb begin
        n_off = r_off;
        base  = r_off;
        if (op_ok) begin
            if (is_pop) begin
                n_off = r_off + OFF_W'(nbytes);
            end else begin
                n_off = r_off - OFF_W'(nbytes);
                base  = n_off;
            end
        end
    end

    // 8-bit push sign-extends to a full 4-byte word.
    always_comb begin
        case (i_in.data.width)
            W_8:     push_word = {{24{i_in.data.push_value[7]}}, i_in.data.push_value[7:0]};
            W_16:    push_word = {16'd0, i_in.data.push_value[15:0]};
            default: push_word = i_in.data.push_value;
        endcase
    end

    // Byte i of the word lives in bank (base + i) mod 4; each bank is hit
    // at most once per transaction, so one port per bank is enough.
    always_comb begin
        logic [1:0]       lane;
        logic [OFF_W-1:0] addr;
        for (int b = 0; b < 4; b++) begin
            lane        = 2'(b) - base[1:0];
            addr        = base + OFF_W'(lane);
            bank_row[b] = ROW_W'(addr >> 2);
            bank_wd[b]  = push_word[{lane, 3'b000} +: 8];
            bank_we[b]  = acc && op_ok && !is_pop && (!is_half || !lane[1]);
            bank_re[b]  = acc && op_ok && is_pop;
        end
    end

    // Four byte-wide banks with registered (synchronous) read.
    // Reads and writes never meet in one cycle: one transaction per edge,
    // and a write lands before the next transaction's read.
    for (genvar g = 0; g < 4; g++) begin : g_bank
        logic [7:0] r_mem [ROWS];

        always_ff @(posedge i_clk) begin
            if (bank_we[g]) begin
                r_mem[bank_row[g]] <= bank_wd[g];
            end
            if (bank_re[g]) begin
                r_rd[g] <= r_mem[bank_row[g]];
            end
        end
    end

    // Reassemble the little-endian pop value from the bank outputs.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            pop_word[8*i +: 8] = r_rd[2'(r_s1_lane0 + 2'(i))];
        end
        if (r_s1_half) begin
            pop_word[31:16] = 16'd0;
        end
        if (!r_s1_pop) begin
            pop_word = '0;
        end
    end

    // Architectural state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off   <= OFF_W'(STACK_BYTES);
            r_start <= '0;
        end else begin
            if (acc) begin
                r_off <= n_off;
            end
            if (i_cfg_we) begin
                r_start <= i_cfg_wdata;
            end
        end
    end

    // Middle stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pop    <= op_ok && is_pop;
            r_s1_half   <= is_half;
            r_s1_lane0  <= base[1:0];
            r_s1_addr   <= r_start + DATA_W'(n_off);
            r_s1_status <= status;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_adv) begin
            r_out.pop_value     <= pop_word;
            r_out.stack_address <= r_s1_addr;
            r_out.status        <= r_s1_status;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef SYNTH
    a_off_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_off <= OFF_W'(STACK_BYTES))
        else $error("stack offset beyond empty top");

    a_off_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> $stable(r_off))
        else $error("stack offset moved without a transaction");

    a_fail_nochange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !op_ok) |=> (r_off == $past(r_off)))
        else $error("failed operation changed the offset");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |-> (r_out.pop_value == '0))
        else $error("failed operation returned nonzero data");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_s1_valid && r_out_valid && !o_out.ready))
        else $error("input stalled with a free stage");
`endif

endmodule
